// ===== sv/vcom_rss_pkg.sv =====
// vcom_rss_pkg: shared constants for the vcom range sweep search block
// opcodes, status codes, register indexes and fixed widths
// no dependencies
package vcom_rss_pkg;

   localparam int CODE_BITS_DEF = 10;

   localparam int OPCODE_BITS  = 2;
   localparam int LEVEL_BITS   = 16;
   localparam int STATUS_BITS  = 3;
   localparam int DELAY_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 16;

   localparam logic [OPCODE_BITS-1:0] OP_START = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_TICK  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_EXIT  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_IDLE    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RUNNING = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_ERROR   = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_EXITED  = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] REG_VCOM_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_VCOM_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_VCOM_STEP = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SETTLE_MS = 2'd3;

   localparam logic [9:0]            VCOM_HIGH_RST = 10'd1023;
   localparam logic [DELAY_BITS-1:0] SETTLE_RST    = 16'd100;
   localparam logic [DELAY_BITS-1:0] DELAY_MAX     = 16'hFFFF;
   localparam logic [LEVEL_BITS-1:0] MIN_FLICKER   = 16'd10;
   localparam int                    RAMP_STEP     = 8;

endpackage

// ===== sv/vcom_rss_if.sv =====
// vcom_rss interfaces: request, response and register write channels
// valid/ready handshake, one beat per accepted edge
// depends on vcom_rss_pkg
interface vcom_rss_req_if;
   import vcom_rss_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic                   meas_ok;
   logic [LEVEL_BITS-1:0]  flicker;
   modport source (output valid, opcode, meas_ok, flicker, input ready);
   modport sink   (input valid, opcode, meas_ok, flicker, output ready);
endinterface

interface vcom_rss_rsp_if #(parameter int CODE_BITS = vcom_rss_pkg::CODE_BITS_DEF);
   import vcom_rss_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   write_valid;
   logic [CODE_BITS-1:0]   write_value;
   logic [STATUS_BITS-1:0] status;
   logic [CODE_BITS-1:0]   best_vcom;
   modport source (output valid, write_valid, write_value, status, best_vcom, input ready);
   modport sink   (input valid, write_valid, write_value, status, best_vcom, output ready);
endinterface

interface vcom_rss_csr_if;
   import vcom_rss_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CSR_DAT_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/vcom_range_sweep_search.sv =====
// vcom_range_sweep_search: top level, sweep / ramp / confirm sequencer for vcom trimming
// depends on vcom_rss_pkg and the vcom_rss interfaces
//
// Takes one request beat per clock (start, millisecond tick or key exit) and returns
// exactly one response beat for each, through the output register. The sequencer
// updates its state in the accept cycle with one saturating add, one compare against
// settle_ms and one code add/compare; the response goes into an output register
// backed by a one-entry skid stage, so requests keep flowing while a response waits.
// req_ch.ready drops only while the skid stage holds a beat. Registers are written
// at any time through csr_ch (always ready) and should change only while idle.
module vcom_range_sweep_search #(
   parameter int CODE_BITS = vcom_rss_pkg::CODE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   vcom_rss_req_if.sink     req_ch,
   vcom_rss_rsp_if.source   rsp_ch,
   vcom_rss_csr_if.sink     csr_ch
);
   import vcom_rss_pkg::*;

   localparam int WIDE_BITS = CODE_BITS + 1;
   localparam logic [CODE_BITS-1:0] HIGH_RST  = CODE_BITS'(VCOM_HIGH_RST);
   localparam logic [WIDE_BITS-1:0] RAMP_WIDE = WIDE_BITS'(RAMP_STEP);

   typedef enum logic [2:0] {
      PH_IDLE, PH_FIRST, PH_SWEEP, PH_RAMP, PH_CONFIRM, PH_DONE, PH_ERROR, PH_EXITED
   } phase_type;

   // config
   logic [CODE_BITS-1:0]  vcom_low_ff, vcom_high_ff, vcom_step_ff;
   logic [DELAY_BITS-1:0] settle_ms_ff;

   // sequencer state
   phase_type             phase_ff, phase_in;
   logic [WIDE_BITS-1:0]  cur_code_ff, cur_code_in;
   logic [CODE_BITS-1:0]  best_code_ff, best_code_in;
   logic [LEVEL_BITS-1:0] best_level_ff, best_level_in;
   logic                  have_best_ff, have_best_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;

   // output buffer
   logic                   out_valid_ff, skid_valid_ff;
   logic                   out_wv_ff, skid_wv_ff;
   logic [CODE_BITS-1:0]   out_wval_ff, skid_wval_ff;
   logic [STATUS_BITS-1:0] out_status_ff, skid_status_ff;
   logic [CODE_BITS-1:0]   out_best_ff, skid_best_ff;

   logic                   accept, running, bad_reading, out_free;
   logic [DELAY_BITS-1:0]  delay_inc;
   logic [WIDE_BITS-1:0]   next_code, ramp_limit;
   logic                   wv_in;
   logic [CODE_BITS-1:0]   wval_in;
   logic [STATUS_BITS-1:0] status_in;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !skid_valid_ff;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   assign running     = (phase_ff == PH_FIRST) || (phase_ff == PH_SWEEP) ||
                        (phase_ff == PH_RAMP) || (phase_ff == PH_CONFIRM);
   assign bad_reading = !req_ch.meas_ok || (req_ch.flicker < MIN_FLICKER);
   assign delay_inc   = (delay_ff == DELAY_MAX) ? delay_ff : delay_ff + 1'b1;
   assign next_code   = cur_code_ff + {1'b0, vcom_step_ff};
   assign ramp_limit  = {1'b0, best_code_ff} + RAMP_WIDE;

   always_comb begin
      phase_in      = phase_ff;
      cur_code_in   = cur_code_ff;
      best_code_in  = best_code_ff;
      best_level_in = best_level_ff;
      have_best_in  = have_best_ff;
      delay_in      = delay_ff;
      wv_in         = 1'b0;
      wval_in       = '0;
      if (accept) begin
         case (req_ch.opcode)
            OP_START: begin
               phase_in      = PH_FIRST;
               cur_code_in   = {1'b0, vcom_low_ff};
               best_code_in  = '0;
               best_level_in = '0;
               have_best_in  = 1'b0;
               delay_in      = '0;
            end
            OP_EXIT: begin
               if (running) phase_in = PH_EXITED;
            end
            OP_TICK: begin
               if (running) begin
                  if (delay_inc >= settle_ms_ff) begin
                     delay_in = '0;
                     case (phase_ff)
                        PH_FIRST: begin
                           wv_in    = 1'b1;
                           wval_in  = cur_code_ff[CODE_BITS-1:0];
                           phase_in = PH_SWEEP;
                        end
                        PH_SWEEP: begin
                           if (bad_reading) begin
                              phase_in = PH_ERROR;
                           end else begin
                              if (!have_best_ff || req_ch.flicker < best_level_ff) begin
                                 have_best_in  = 1'b1;
                                 best_level_in = req_ch.flicker;
                                 best_code_in  = cur_code_ff[CODE_BITS-1:0];
                              end
                              cur_code_in = next_code;
                              if (next_code <= {1'b0, vcom_high_ff}) begin
                                 wv_in   = 1'b1;
                                 wval_in = next_code[CODE_BITS-1:0];
                              end else begin
                                 phase_in = PH_RAMP;
                              end
                           end
                        end
                        PH_RAMP: begin
                           wv_in = 1'b1;
                           if (cur_code_ff > ramp_limit) begin
                              cur_code_in = cur_code_ff - RAMP_WIDE;
                              wval_in     = cur_code_in[CODE_BITS-1:0];
                           end else begin
                              cur_code_in = {1'b0, best_code_ff};
                              wval_in     = best_code_ff;
                              phase_in    = PH_CONFIRM;
                           end
                        end
                        default: begin
                           phase_in = bad_reading ? PH_ERROR : PH_DONE;
                        end
                     endcase
                  end else begin
                     delay_in = delay_inc;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (phase_in)
         PH_IDLE:   status_in = STATUS_IDLE;
         PH_DONE:   status_in = STATUS_DONE;
         PH_ERROR:  status_in = STATUS_ERROR;
         PH_EXITED: status_in = STATUS_EXITED;
         default:   status_in = STATUS_RUNNING;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcom_low_ff   <= '0;
         vcom_high_ff  <= HIGH_RST;
         vcom_step_ff  <= CODE_BITS'(1);
         settle_ms_ff  <= SETTLE_RST;
         phase_ff      <= PH_IDLE;
         cur_code_ff   <= '0;
         best_code_ff  <= '0;
         best_level_ff <= '0;
         have_best_ff  <= 1'b0;
         delay_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            case (csr_ch.index)
               REG_VCOM_LOW:  vcom_low_ff  <= csr_ch.data[CODE_BITS-1:0];
               REG_VCOM_HIGH: vcom_high_ff <= csr_ch.data[CODE_BITS-1:0];
               REG_VCOM_STEP: vcom_step_ff <= csr_ch.data[CODE_BITS-1:0];
               REG_SETTLE_MS: settle_ms_ff <= csr_ch.data;
               default: ;
            endcase
         end
         phase_ff      <= phase_in;
         cur_code_ff   <= cur_code_in;
         best_code_ff  <= best_code_in;
         best_level_ff <= best_level_in;
         have_best_ff  <= have_best_in;
         delay_ff      <= delay_in;
         // response beat lands in the output register, or in the skid stage when held
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               out_wv_ff     <= skid_wv_ff;
               out_wval_ff   <= skid_wval_ff;
               out_status_ff <= skid_status_ff;
               out_best_ff   <= skid_best_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff  <= accept;
               out_wv_ff     <= wv_in;
               out_wval_ff   <= wval_in;
               out_status_ff <= status_in;
               out_best_ff   <= best_code_in;
            end
         end else if (accept) begin
            skid_valid_ff  <= 1'b1;
            skid_wv_ff     <= wv_in;
            skid_wval_ff   <= wval_in;
            skid_status_ff <= status_in;
            skid_best_ff   <= best_code_in;
         end
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.write_valid = out_wv_ff;
   assign rsp_ch.write_value = out_wval_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.best_vcom   = out_best_ff;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a beat while output register is empty");

   a_wval_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_wv_ff |-> out_wval_ff == '0)
      else $error("write_value not zero without write_valid");

   a_start_first: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.opcode == OP_START |=> phase_ff == PH_FIRST && delay_ff == '0)
      else $error("start did not restart the sweep");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE || phase_ff == PH_ERROR || phase_ff == PH_EXITED) &&
      !(accept && req_ch.opcode == OP_START) |=> $stable(phase_ff))
      else $error("finished search left its end phase without a start");

   a_delay_bound: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.opcode == OP_TICK && running |=> delay_ff < settle_ms_ff ||
      delay_ff == '0)
      else $error("delay counter passed settle time without acting");
`endif

endmodule

// ===== tb/sv/tb_vcom_range_sweep_search.sv =====
`timescale 1ns / 1ps
// tb_vcom_range_sweep_search: self-checking bench for the vcom range sweep search block
// scoreboard class predicts every response beat; tasks drive request and register channels
// depends on vcom_rss_pkg, the vcom_rss interfaces and vcom_range_sweep_search
module tb_vcom_range_sweep_search;
   import vcom_rss_pkg::*;

   localparam int CODE_W      = CODE_BITS_DEF;
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_BEATS = 1150;
   localparam int SEARCH_CAP  = 400;
   localparam int LONG_WAIT_TICKS = 24;

   localparam logic [OPCODE_BITS-1:0] OP_SPARE = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE, PH_FIRST, PH_SWEEP, PH_RAMP, PH_CONFIRM, PH_DONE, PH_ERROR, PH_EXITED
   } sweep_phase_type;

   typedef struct packed {
      logic                   write_valid;
      logic [CODE_W-1:0]      write_value;
      logic [STATUS_BITS-1:0] status;
      logic [CODE_W-1:0]      best_vcom;
   } sweep_rsp_type;

   class vcom_sweep_scoreboard;
      logic [CODE_W-1:0]     low_code;
      logic [CODE_W-1:0]     high_code;
      logic [CODE_W-1:0]     step_code;
      logic [DELAY_BITS-1:0] settle;
      sweep_phase_type       phase;
      logic [CODE_W:0]       cur_code;
      logic [CODE_W-1:0]     best_code;
      logic [LEVEL_BITS-1:0] best_level;
      bit                    have_best;
      logic [DELAY_BITS-1:0] tick_count;
      sweep_rsp_type         expected_q[$];
      int                    failures;

      function new();
         low_code   = '0;
         high_code  = VCOM_HIGH_RST;
         step_code  = CODE_W'(1);
         settle     = SETTLE_RST;
         phase      = PH_IDLE;
         cur_code   = '0;
         best_code  = '0;
         best_level = '0;
         have_best  = 1'b0;
         tick_count = '0;
         failures   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DAT_BITS-1:0] data);
         case (idx)
            REG_VCOM_LOW:  low_code  = data[CODE_W-1:0];
            REG_VCOM_HIGH: high_code = data[CODE_W-1:0];
            REG_VCOM_STEP: step_code = data[CODE_W-1:0];
            REG_SETTLE_MS: settle    = data;
            default: ;
         endcase
      endfunction

      function bit searching();
         return phase inside {PH_FIRST, PH_SWEEP, PH_RAMP, PH_CONFIRM};
      endfunction

      function void note_request(logic [OPCODE_BITS-1:0] op, logic ok,
                                 logic [LEVEL_BITS-1:0] lvl);
         sweep_rsp_type exp_rsp;
         bit            bad;
         bad     = !ok || lvl < MIN_FLICKER;
         exp_rsp = '0;
         case (op)
            OP_START: begin
               phase      = PH_FIRST;
               cur_code   = {1'b0, low_code};
               best_code  = '0;
               best_level = '0;
               have_best  = 1'b0;
               tick_count = '0;
            end
            OP_EXIT: begin
               if (searching()) phase = PH_EXITED;
            end
            OP_TICK: begin
               if (searching()) begin
                  if (tick_count != DELAY_MAX) tick_count++;
                  if (tick_count >= settle) begin
                     tick_count = '0;
                     case (phase)
                        PH_FIRST: begin
                           exp_rsp.write_valid = 1'b1;
                           exp_rsp.write_value = cur_code[CODE_W-1:0];
                           phase = PH_SWEEP;
                        end
                        PH_SWEEP: begin
                           if (bad) begin
                              phase = PH_ERROR;
                           end else begin
                              if (!have_best || lvl < best_level) begin
                                 have_best  = 1'b1;
                                 best_level = lvl;
                                 best_code  = cur_code[CODE_W-1:0];
                              end
                              cur_code = cur_code + {1'b0, step_code};
                              if (cur_code <= {1'b0, high_code}) begin
                                 exp_rsp.write_valid = 1'b1;
                                 exp_rsp.write_value = cur_code[CODE_W-1:0];
                              end else begin
                                 phase = PH_RAMP;
                              end
                           end
                        end
                        PH_RAMP: begin
                           exp_rsp.write_valid = 1'b1;
                           if (int'(cur_code) > int'(best_code) + RAMP_STEP) begin
                              cur_code = cur_code - (CODE_W+1)'(RAMP_STEP);
                           end else begin
                              cur_code = {1'b0, best_code};
                              phase    = PH_CONFIRM;
                           end
                           exp_rsp.write_value = cur_code[CODE_W-1:0];
                        end
                        default: phase = bad ? PH_ERROR : PH_DONE;
                     endcase
                  end
               end
            end
            default: ;
         endcase
         case (phase)
            PH_IDLE:   exp_rsp.status = STATUS_IDLE;
            PH_DONE:   exp_rsp.status = STATUS_DONE;
            PH_ERROR:  exp_rsp.status = STATUS_ERROR;
            PH_EXITED: exp_rsp.status = STATUS_EXITED;
            default:   exp_rsp.status = STATUS_RUNNING;
         endcase
         exp_rsp.best_vcom = best_code;
         expected_q.push_back(exp_rsp);
      endfunction

      function void check_response(sweep_rsp_type got);
         sweep_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response beat with no request pending");
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.write_valid !== want.write_valid) begin
            $error("write_valid: expected %0d, got %0d", want.write_valid, got.write_valid);
            failures++;
         end
         if (got.write_value !== want.write_value) begin
            $error("write_value: expected %0d, got %0d", want.write_value, got.write_value);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.best_vcom !== want.best_vcom) begin
            $error("best_vcom: expected %0d, got %0d", want.best_vcom, got.best_vcom);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   vcom_rss_req_if req_ch ();
   vcom_rss_rsp_if rsp_ch ();
   vcom_rss_csr_if csr_ch ();

   vcom_range_sweep_search dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   vcom_sweep_scoreboard sb = new();

   int burst_left  = 0;
   int stall_cycles = 0;
   int pat_cnt     = 0;
   int pat_mode    = 0;

   always #4 clock = ~clock;

   // receiver back-pressure, mode redrawn at random whenever the pattern counter runs out
   always @(negedge clock) begin
      if (pat_cnt == 0) begin
         pat_mode = $urandom_range(0, 3);
         pat_cnt  = 64;
      end
      pat_cnt--;
      case (pat_mode)
         0: rsp_ch.ready = 1'b1;
         1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready = (pat_cnt % 3 != 0);
         default: rsp_ch.ready = (pat_cnt % 32 >= 16) || ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response({rsp_ch.write_valid, rsp_ch.write_value, rsp_ch.status,
                            rsp_ch.best_vcom});
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(input logic [OPCODE_BITS-1:0] op, input logic ok,
                            input logic [LEVEL_BITS-1:0] lvl);
      int gap;
      int roll;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         roll = $urandom_range(0, 9);
         gap  = (roll < 3) ? 0 : (roll < 8) ? $urandom_range(1, 3) : $urandom_range(4, 20);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_ch.valid   = 1'b1;
      req_ch.opcode  = op;
      req_ch.meas_ok = ok;
      req_ch.flicker = lvl;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(op, ok, lvl);
      burst_left--;
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DAT_BITS-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      sb.write_reg(idx, data);
   endtask

   // code registers get random junk in the unused upper data bits
   task automatic set_regs(input int low, input int high, input int step, input int settle_val,
                           input bit [3:0] pick);
      if (pick[0]) write_csr(REG_VCOM_LOW,  {6'($urandom), 10'(low)});
      if (pick[1]) write_csr(REG_VCOM_HIGH, {6'($urandom), 10'(high)});
      if (pick[2]) write_csr(REG_VCOM_STEP, {6'($urandom), 10'(step)});
      if (pick[3]) write_csr(REG_SETTLE_MS, 16'(settle_val));
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic good_tick();
      send_item(OP_TICK, 1'b1, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(10, 65535))
                                                            : 16'($urandom_range(10, 400)));
   endtask

   initial begin
      int done_beats;
      int n;
      int roll;
      int low;
      int high;
      int step;
      int settle_val;
      bit [3:0] pick;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = OP_TICK;
      req_ch.meas_ok = 1'b0;
      req_ch.flicker = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_VCOM_LOW;
      csr_ch.data    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // register reset values: idle tick, then one full settle at the default
      send_item(OP_TICK, 1'b1, 16'd300);
      send_item(OP_START, 1'b0, 16'd0);
      repeat (int'(SETTLE_RST)) good_tick();
      send_item(OP_EXIT, 1'b1, 16'd0);
      drain();

      set_regs(5, 30, 10, 0, 4'hF);
      send_item(OP_TICK, 1'b1, 16'd50);
      send_item(OP_EXIT, 1'b0, 16'hFFFF);
      send_item(OP_SPARE, 1'b1, 16'h8000);
      send_item(OP_START, 1'b1, 16'd0);
      send_item(OP_TICK, 1'b1, 16'd0);
      send_item(OP_TICK, 1'b1, 16'hFFFF);
      send_item(OP_TICK, 1'b1, MIN_FLICKER);
      send_item(OP_TICK, 1'b1, MIN_FLICKER);
      send_item(OP_TICK, 1'b0, 16'd0);
      send_item(OP_TICK, 1'b0, 16'd0);
      send_item(OP_TICK, 1'b0, 16'd0);
      send_item(OP_TICK, 1'b1, 16'd500);
      send_item(OP_TICK, 1'b1, 16'd500);
      send_item(OP_START, 1'b0, 16'd0);
      send_item(OP_TICK, 1'b0, 16'd0);
      send_item(OP_TICK, 1'b0, 16'd300);
      send_item(OP_START, 1'b1, 16'd0);
      send_item(OP_TICK, 1'b1, 16'd9);
      send_item(OP_TICK, 1'b1, 16'd9);
      send_item(OP_START, 1'b1, 16'd0);
      send_item(OP_TICK, 1'b1, 16'd100);
      send_item(OP_START, 1'b1, 16'd0);
      send_item(OP_EXIT, 1'b1, 16'd0);
      send_item(OP_EXIT, 1'b1, 16'd0);
      drain();

      // low above high, confirm reading fails
      set_regs(1023, 0, 1, 1, 4'hF);
      send_item(OP_START, 1'b1, 16'd0);
      send_item(OP_TICK, 1'b1, 16'd200);
      send_item(OP_TICK, 1'b1, 16'd200);
      send_item(OP_TICK, 1'b1, 16'd200);
      send_item(OP_TICK, 1'b0, 16'd200);
      drain();

      done_beats = 0;
      while (done_beats < RANDOM_BEATS) begin
         roll = $urandom_range(0, 19);
         step = $urandom_range(1, 64);
         low  = $urandom_range(0, 1023);
         high = low + step * $urandom_range(0, 12);
         if (high > 1023) high = 1023;
         case (roll)
            0: step = 0;
            1: begin
               low  = $urandom_range(1, 1023);
               high = $urandom_range(0, low - 1);
            end
            2: begin
               step = 1023;
               high = 1023;
            end
            3: begin
               low  = 0;
               high = 1023;
               step = $urandom_range(64, 1023);
            end
            4: begin
               low  = 1023;
               high = 1023;
            end
            default: ;
         endcase
         settle_val = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
         pick = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
         set_regs(low, high, step, settle_val, pick);

         if ($urandom_range(0, 3) == 0)
            send_item(2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom));
         send_item(OP_START, 1'($urandom), 16'($urandom));
         n = 0;
         while (sb.searching() && n < SEARCH_CAP) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
               send_item(OP_EXIT, 1'($urandom), 16'($urandom));
            else if (roll < 4)
               send_item(OP_START, 1'($urandom), 16'($urandom));
            else if (roll < 6)
               send_item(OP_SPARE, 1'($urandom), 16'($urandom));
            else if (roll < 8)
               send_item(OP_TICK, 1'b0, 16'($urandom));
            else if (roll < 9)
               send_item(OP_TICK, 1'b1, 16'($urandom_range(0, 9)));
            else
               good_tick();
            n++;
         end
         if (sb.searching()) send_item(OP_EXIT, 1'($urandom), 16'($urandom));
         if ($urandom_range(0, 2) == 0)
            send_item(2'($urandom_range(1, 3)), 1'($urandom), 16'($urandom));
         done_beats += n + 1;
         drain();
      end

      // longest settle: no write while waiting, then key exit
      set_regs(1023, 1023, 1, 65535, 4'hF);
      send_item(OP_START, 1'b1, 16'd0);
      repeat (LONG_WAIT_TICKS) good_tick();
      send_item(OP_EXIT, 1'b1, 16'd0);
      drain();

      if (sb.expected_q.size() != 0) begin
         $error("%0d expected response beats never arrived", sb.expected_q.size());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
